FILE: rtl/thumb_instruction_decoder_unit_defines.svh
// Assertion macros used by the Thumb decoder top level.
`ifndef THUMB_INSTRUCTION_DECODER_UNIT_DEFINES_SVH
`define THUMB_INSTRUCTION_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define TIDEC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define TIDEC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder check failed");

`endif

FILE: rtl/tidec_pkg.sv
// Types and constants shared by the Thumb instruction decoder.
package tidec_pkg;

    localparam logic [5:0] FORM_NONE      = 6'd0;
    localparam logic [5:0] FORM_LSL_IMM   = 6'd1;
    localparam logic [5:0] FORM_LSR_IMM   = 6'd2;
    localparam logic [5:0] FORM_ASR_IMM   = 6'd3;
    localparam logic [5:0] FORM_ADD_REG   = 6'd4;
    localparam logic [5:0] FORM_SUB_REG   = 6'd5;
    localparam logic [5:0] FORM_ADD_IMM3  = 6'd6;
    localparam logic [5:0] FORM_SUB_IMM3  = 6'd7;
    localparam logic [5:0] FORM_MOV_LOW   = 6'd8;
    localparam logic [5:0] FORM_MOV_IMM8  = 6'd9;
    localparam logic [5:0] FORM_ADD_HIGH  = 6'd13;
    localparam logic [5:0] FORM_MOV_HIGH  = 6'd14;
    localparam logic [5:0] FORM_CMP_HIGH  = 6'd15;
    localparam logic [5:0] FORM_BX        = 6'd16;
    localparam logic [5:0] FORM_BLX       = 6'd17;
    localparam logic [5:0] FORM_ADD_SP    = 6'd18;
    localparam logic [5:0] FORM_SUB_SP    = 6'd19;
    localparam logic [5:0] FORM_STR_IMM5  = 6'd20;
    localparam logic [5:0] FORM_LDR_IMM5  = 6'd21;
    localparam logic [5:0] FORM_STR_SP    = 6'd22;
    localparam logic [5:0] FORM_LDR_SP    = 6'd23;
    localparam logic [5:0] FORM_STM       = 6'd24;
    localparam logic [5:0] FORM_LDM       = 6'd25;
    localparam logic [5:0] FORM_POP       = 6'd26;
    localparam logic [5:0] FORM_STMDB     = 6'd27;
    localparam logic [5:0] FORM_PUSH      = 6'd28;
    localparam logic [5:0] FORM_LDMDB     = 6'd29;
    localparam logic [5:0] FORM_STRW_IMM  = 6'd30;
    localparam logic [5:0] FORM_LDRW_IMM  = 6'd31;
    localparam logic [5:0] FORM_LDRW_REG  = 6'd32;
    localparam logic [5:0] FORM_LDRT      = 6'd33;

    localparam logic [3:0] REG_SP = 4'd13;
    localparam logic [3:0] REG_PC = 4'd15;

    // Top bits of a halfword that opens a 32-bit instruction.
    localparam logic [3:0] PREFIX_F  = 4'hF;
    localparam logic [4:0] PREFIX_E8 = 5'b11101;

    typedef struct packed {
        logic [5:0]  form;
        logic [3:0]  dest_reg;
        logic [3:0]  base_reg;
        logic [3:0]  index_reg;
        logic [11:0] immediate;
        logic [1:0]  shift_amount;
        logic [15:0] reg_mask;
        logic        writeback;
    } dec_t;

    localparam dec_t DEC_ZERO = '0;

endpackage

FILE: rtl/tidec_narrow.sv
// Field decoder for 16-bit Thumb instructions.
module tidec_narrow (
    input  logic [15:0]   hw,
    output tidec_pkg::dec_t dec
);
    import tidec_pkg::*;

    logic [2:0] lo3;
    logic [2:0] mid3;
    logic [2:0] hi3;
    logic [4:0] op5;
    logic [3:0] op4;
    logic [3:0] rm4;
    logic [3:0] rdn4;
    logic [1:0] k2;

    assign lo3  = hw[2:0];
    assign mid3 = hw[5:3];
    assign hi3  = hw[8:6];
    assign op5  = hw[13:9];
    assign op4  = hw[9:6];
    assign rm4  = hw[6:3];
    assign rdn4 = {hw[7], hw[2:0]};
    assign k2   = hw[12:11];

    always_comb
    begin
        dec = DEC_ZERO;
        if (hw[15:14] == 2'b00)
        begin
            if (op5 <= 5'd11)
            begin
                dec.form      = (op5 <= 5'd3) ? FORM_LSL_IMM :
                                (op5 <= 5'd7) ? FORM_LSR_IMM : FORM_ASR_IMM;
                dec.dest_reg  = {1'b0, lo3};
                dec.base_reg  = {1'b0, mid3};
                dec.immediate = {7'd0, hw[10:6]};
            end
            else if (op5 <= 5'd15)
            begin
                dec.dest_reg = {1'b0, lo3};
                dec.base_reg = {1'b0, mid3};
                if (!op5[1])
                begin
                    dec.form      = op5[0] ? FORM_SUB_REG : FORM_ADD_REG;
                    dec.index_reg = {1'b0, hi3};
                end
                else if (hi3 == 3'd0)
                begin
                    dec.form = FORM_MOV_LOW;
                end
                else
                begin
                    dec.form      = op5[0] ? FORM_SUB_IMM3 : FORM_ADD_IMM3;
                    dec.immediate = {9'd0, hi3};
                end
            end
            else
            begin
                // MOVS, CMP, ADDS and SUBS with imm8 are consecutive codes.
                dec.form      = FORM_MOV_IMM8 + {4'd0, k2};
                dec.immediate = {4'd0, hw[7:0]};
                if (k2 == 2'd1)
                begin
                    dec.base_reg = {1'b0, hw[10:8]};
                end
                else
                begin
                    dec.dest_reg = {1'b0, hw[10:8]};
                end
            end
        end
        else if (hw[15:10] == 6'b010001)
        begin
            if (op4 <= 4'd3)
            begin
                dec.form      = FORM_ADD_HIGH;
                dec.dest_reg  = rdn4;
                dec.base_reg  = rdn4;
                dec.index_reg = rm4;
            end
            else if (op4 >= 4'd8 && op4 <= 4'd11)
            begin
                dec.form     = FORM_MOV_HIGH;
                dec.dest_reg = rdn4;
                dec.base_reg = rm4;
            end
            else if (op4 >= 4'd5 && op4 <= 4'd7)
            begin
                dec.form      = FORM_CMP_HIGH;
                dec.base_reg  = rdn4;
                dec.index_reg = rm4;
            end
            else if (op4 >= 4'd12)
            begin
                dec.form      = op4[1] ? FORM_BLX : FORM_BX;
                dec.index_reg = rm4;
            end
        end
        else if (hw[15:12] == 4'hB)
        begin
            if (hw[11:8] == 4'h0)
            begin
                dec.form      = hw[7] ? FORM_SUB_SP : FORM_ADD_SP;
                dec.dest_reg  = REG_SP;
                dec.base_reg  = REG_SP;
                dec.immediate = {3'd0, hw[6:0], 2'b00};
            end
        end
        else if (hw[15:12] == 4'h6)
        begin
            dec.form      = hw[11] ? FORM_LDR_IMM5 : FORM_STR_IMM5;
            dec.dest_reg  = {1'b0, lo3};
            dec.base_reg  = {1'b0, mid3};
            dec.immediate = {5'd0, hw[10:6], 2'b00};
        end
        else if (hw[15:12] == 4'h9)
        begin
            dec.form      = hw[11] ? FORM_LDR_SP : FORM_STR_SP;
            dec.dest_reg  = {1'b0, hw[10:8]};
            dec.base_reg  = REG_SP;
            dec.immediate = {2'd0, hw[7:0], 2'b00};
        end
    end

endmodule

FILE: rtl/tidec_wide.sv
// Field decoder for 32-bit Thumb instructions.
module tidec_wide (
    input  logic [31:0]   word,
    output tidec_pkg::dec_t dec
);
    import tidec_pkg::*;

    logic [1:0] op1;
    logic [1:0] opm;
    logic [3:0] rn;
    logic [3:0] rt;
    logic       load;

    assign op1  = word[28:27];
    assign opm  = word[24:23];
    assign rn   = word[19:16];
    assign rt   = word[15:12];
    assign load = word[20];

    always_comb
    begin
        dec = DEC_ZERO;
        if (op1 == 2'd1)
        begin
            // Load/store multiple: op2 bits 6, 5 and 2 clear.
            if (!word[26] && !word[25] && !word[22] && (opm == 2'd1 || opm == 2'd2))
            begin
                if (opm == 2'd1)
                begin
                    dec.form = !load ? FORM_STM : ((rn != REG_SP) ? FORM_LDM : FORM_POP);
                end
                else
                begin
                    dec.form = load ? FORM_LDMDB : ((rn != REG_SP) ? FORM_STMDB : FORM_PUSH);
                end
                dec.base_reg  = rn;
                dec.reg_mask  = word[15:0];
                dec.writeback = word[21];
            end
        end
        else if (op1 == 2'd3)
        begin
            if (word[26:24] == 3'd0 && !word[20])
            begin
                if (word[23:21] == 3'd6)
                begin
                    dec.form      = FORM_STRW_IMM;
                    dec.dest_reg  = rt;
                    dec.base_reg  = rn;
                    dec.immediate = word[11:0];
                end
            end
            else if (word[26:25] == 2'd0 && word[22:20] == 3'b101)
            begin
                dec.dest_reg = rt;
                dec.base_reg = rn;
                if (opm == 2'd1 || rn == REG_PC)
                begin
                    dec.form      = FORM_LDRW_IMM;
                    dec.immediate = word[11:0];
                end
                else if (word[11:6] == 6'd0)
                begin
                    dec.form         = FORM_LDRW_REG;
                    dec.index_reg    = word[3:0];
                    dec.shift_amount = word[5:4];
                end
                else
                begin
                    dec.form      = FORM_LDRT;
                    dec.immediate = {4'd0, word[7:0]};
                end
            end
        end
    end

endmodule

FILE: rtl/thumb_instruction_decoder_unit.sv
// Thumb instruction decoder top level: prefix pairing, input and result registers.
//
//   channel | signals                          | direction
//   input   | in_valid, in_stall, halfword     | halfwords in program order
//   output  | out_valid, out_stall, form..raw  | one decoded instruction per transaction
//
// One halfword is taken every cycle while the result side keeps up.
// A 32-bit prefix halfword is held and gives no transaction of its own.
// A result passes the input register, then the field decoders and the result register.
// Reset clears the held prefix and both valid flags; a stall backs up one stage at a time.
`include "thumb_instruction_decoder_unit_defines.svh"

module thumb_instruction_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] halfword,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  form,
    output logic        wide,
    output logic [3:0]  dest_reg,
    output logic [3:0]  base_reg,
    output logic [3:0]  index_reg,
    output logic [11:0] immediate,
    output logic [1:0]  shift_amount,
    output logic [15:0] reg_mask,
    output logic        writeback,
    output logic [31:0] raw_word
);
    import tidec_pkg::*;

    logic        held_valid_reg;
    logic        held_valid_next;
    logic [15:0] held_hw_reg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [31:0] s1_word_reg;
    logic        s1_wide_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    dec_t        out_dec_reg;
    logic        out_wide_reg;
    logic [31:0] out_raw_reg;

    logic in_acc;
    logic s1_load;
    logic out_load;
    logic is_prefix;
    logic fields_clear;
    dec_t narrow_dec;
    dec_t wide_dec;
    dec_t sel_dec;

    assign out_load  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_load   = !s1_valid_reg || out_load;
    assign in_stall  = !s1_load;
    assign in_acc    = in_valid && s1_load;
    assign is_prefix = (halfword[15:12] == PREFIX_F) || (halfword[15:11] == PREFIX_E8);

    tidec_narrow u_narrow (
        .hw  (s1_word_reg[15:0]),
        .dec (narrow_dec)
    );

    tidec_wide u_wide (
        .word (s1_word_reg),
        .dec  (wide_dec)
    );

    assign sel_dec = s1_wide_reg ? wide_dec : narrow_dec;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        s1_valid_next   = out_load ? 1'b0 : s1_valid_reg;
        if (in_acc)
        begin
            // A held prefix is completed by whatever halfword follows it.
            held_valid_next = !held_valid_reg && is_prefix;
            s1_valid_next   = held_valid_reg || !is_prefix;
        end
        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            held_hw_reg <= halfword;
            s1_wide_reg <= held_valid_reg;
            s1_word_reg <= held_valid_reg ? {held_hw_reg, halfword} : {16'd0, halfword};
        end
        if (out_load)
        begin
            out_dec_reg  <= sel_dec;
            out_wide_reg <= s1_wide_reg;
            out_raw_reg  <= s1_word_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign form         = out_dec_reg.form;
    assign wide         = out_wide_reg;
    assign dest_reg     = out_dec_reg.dest_reg;
    assign base_reg     = out_dec_reg.base_reg;
    assign index_reg    = out_dec_reg.index_reg;
    assign immediate    = out_dec_reg.immediate;
    assign shift_amount = out_dec_reg.shift_amount;
    assign reg_mask     = out_dec_reg.reg_mask;
    assign writeback    = out_dec_reg.writeback;
    assign raw_word     = out_raw_reg;

    assign fields_clear = (dest_reg == 4'd0) && (immediate == 12'd0) && (reg_mask == 16'd0);

    `TIDEC_ASSERT_NXT(a_prefix_held, in_acc && !held_valid_reg && is_prefix, held_valid_reg)
    `TIDEC_ASSERT_NXT(a_paired, in_acc && held_valid_reg, !held_valid_reg && s1_valid_reg && s1_wide_reg)
    `TIDEC_ASSERT_IMP(a_stall_full, in_stall, s1_valid_reg && out_valid_reg)
    `TIDEC_ASSERT_IMP(a_narrow_codes, out_valid_reg && !out_wide_reg, form <= FORM_LDR_SP)
    `TIDEC_ASSERT_IMP(a_wide_codes, out_valid_reg && out_wide_reg && (form != FORM_NONE), form >= FORM_STM)
    `TIDEC_ASSERT_IMP(a_unknown_clear, out_valid_reg && (form == FORM_NONE), fields_clear)

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the Thumb instruction decoder: directed table, then random stream.
module tb;
    import tidec_pkg::*;

    // Immediate forms that the package does not name.
    localparam logic [5:0] FORM_CMP_IMM8 = 6'd10;
    localparam logic [5:0] FORM_ADD_IMM8 = 6'd11;
    localparam logic [5:0] FORM_SUB_IMM8 = 6'd12;

    // Major opcode groups of the first halfword of a 32-bit instruction.
    localparam logic [1:0] OP1_LDM_STM   = 2'd1;
    localparam logic [1:0] OP1_LOAD_STORE = 2'd3;

    localparam int RESET_CYCLES  = 10;
    localparam int ITEM_TARGET   = 1850;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [5:0]  form;
        logic        wide;
        logic [3:0]  dest_reg;
        logic [3:0]  base_reg;
        logic [3:0]  index_reg;
        logic [11:0] immediate;
        logic [1:0]  shift_amount;
        logic [15:0] reg_mask;
        logic        writeback;
        logic [31:0] raw_word;
    } decoded_t;

    typedef struct packed {
        logic [15:0] hw;
        logic        typed;
        decoded_t    res;
    } row_t;

    localparam decoded_t NO_RES = '0;

    localparam int DIRECTED_COUNT = 39;
    localparam row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{16'h0000, 1'b1, '{FORM_LSL_IMM, 1'b0, 4'd0, 4'd0, 4'd0, 12'd0, 2'd0, 16'h0000,
                            1'b0, 32'h0000_0000}},
        '{16'h1FFF, 1'b0, NO_RES},
        '{16'h1C00, 1'b0, NO_RES},
        '{16'h1800, 1'b0, NO_RES},
        '{16'h0FFF, 1'b0, NO_RES},
        '{16'h17FF, 1'b0, NO_RES},
        '{16'h27FF, 1'b0, NO_RES},
        '{16'h2FFF, 1'b0, NO_RES},
        '{16'h37FF, 1'b0, NO_RES},
        '{16'h3FFF, 1'b0, NO_RES},
        '{16'h1DFF, 1'b0, NO_RES},
        '{16'h44FF, 1'b0, NO_RES},
        '{16'h4600, 1'b0, NO_RES},
        '{16'h45FF, 1'b0, NO_RES},
        '{16'h4700, 1'b1, '{FORM_BX, 1'b0, 4'd0, 4'd0, 4'd0, 12'd0, 2'd0, 16'h0000,
                            1'b0, 32'h0000_4700}},
        '{16'h47F8, 1'b0, NO_RES},
        '{16'hB07F, 1'b0, NO_RES},
        '{16'hB0FF, 1'b0, NO_RES},
        '{16'h6000, 1'b0, NO_RES},
        '{16'h6FFF, 1'b0, NO_RES},
        '{16'h9000, 1'b0, NO_RES},
        '{16'h9FFF, 1'b0, NO_RES},
        '{16'hDE00, 1'b1, '{FORM_NONE, 1'b0, 4'd0, 4'd0, 4'd0, 12'd0, 2'd0, 16'h0000,
                            1'b0, 32'h0000_DE00}},
        '{16'hE92D, 1'b0, NO_RES},
        '{16'h4FF0, 1'b0, NO_RES},
        '{16'hE8BD, 1'b0, NO_RES},
        '{16'h8FF0, 1'b0, NO_RES},
        '{16'hF8DF, 1'b0, NO_RES},
        '{16'h0FFF, 1'b0, NO_RES},
        '{16'hF8C1, 1'b0, NO_RES},
        '{16'h2FFF, 1'b0, NO_RES},
        '{16'hF851, 1'b0, NO_RES},
        '{16'h0032, 1'b0, NO_RES},
        '{16'hF851, 1'b0, NO_RES},
        '{16'h1E04, 1'b0, NO_RES},
        '{16'hF000, 1'b0, NO_RES},
        '{16'hF000, 1'b0, NO_RES},
        '{16'hFFFF, 1'b0, NO_RES},
        '{16'hFFFF, 1'b1, '{FORM_NONE, 1'b1, 4'd0, 4'd0, 4'd0, 12'd0, 2'd0, 16'h0000,
                            1'b0, 32'hFFFF_FFFF}}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] halfword = 16'h0000;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [5:0]  form;
    logic        wide;
    logic [3:0]  dest_reg;
    logic [3:0]  base_reg;
    logic [3:0]  index_reg;
    logic [11:0] immediate;
    logic [1:0]  shift_amount;
    logic [15:0] reg_mask;
    logic        writeback;
    logic [31:0] raw_word;

    decoded_t    pending_decodes [$];
    logic [15:0] held_first_half = 16'h0000;
    logic        half_pending = 1'b0;
    int          decode_errors = 0;
    int          sent_count = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    logic        tx_calm = 1'b0;
    logic        rx_calm = 1'b0;

    thumb_instruction_decoder_unit u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Returns 1 when the halfword completes an instruction; a prefix is only held.
    function automatic logic predict_decode(input logic [15:0] hw, output decoded_t res);
        logic [31:0] w;
        logic [4:0]  op5;
        logic [3:0]  op4;
        logic [6:0]  op2;
        logic [3:0]  rn;
        logic [3:0]  rdn;
        res = '0;
        if (half_pending)
        begin
            w = {held_first_half, hw};
            half_pending = 1'b0;
            held_first_half = 16'h0000;
            res.wide = 1'b1;
            res.raw_word = w;
            op2 = w[26:20];
            rn = w[19:16];
            if (w[28:27] == OP1_LDM_STM)
            begin
                if ((op2 & 7'h64) == 7'h00 && (w[24:23] == 2'd1 || w[24:23] == 2'd2))
                begin
                    if (w[24:23] == 2'd1)
                        res.form = !w[20] ? FORM_STM : (rn != REG_SP ? FORM_LDM : FORM_POP);
                    else
                        res.form = w[20] ? FORM_LDMDB : (rn != REG_SP ? FORM_STMDB : FORM_PUSH);
                    res.base_reg = rn;
                    res.reg_mask = w[15:0];
                    res.writeback = w[21];
                end
            end
            else if (w[28:27] == OP1_LOAD_STORE)
            begin
                if ((op2 & 7'h71) == 7'h00)
                begin
                    if (w[23:21] == 3'd6)
                    begin
                        res.form = FORM_STRW_IMM;
                        res.dest_reg = w[15:12];
                        res.base_reg = rn;
                        res.immediate = w[11:0];
                    end
                end
                else if ((op2 & 7'h67) == 7'h05)
                begin
                    res.dest_reg = w[15:12];
                    res.base_reg = rn;
                    if (w[24:23] == 2'd1 || rn == REG_PC)
                    begin
                        res.form = FORM_LDRW_IMM;
                        res.immediate = w[11:0];
                    end
                    else if (w[11:6] == 6'd0)
                    begin
                        res.form = FORM_LDRW_REG;
                        res.index_reg = w[3:0];
                        res.shift_amount = w[5:4];
                    end
                    else
                    begin
                        res.form = FORM_LDRT;
                        res.immediate = {4'd0, w[7:0]};
                    end
                end
            end
            return 1'b1;
        end
        if (hw[15:12] == PREFIX_F || hw[15:11] == PREFIX_E8)
        begin
            held_first_half = hw;
            half_pending = 1'b1;
            return 1'b0;
        end
        res.raw_word = {16'h0000, hw};
        if (hw[15:14] == 2'b00)
        begin
            op5 = hw[13:9];
            if (op5 <= 5'd11)
            begin
                res.form = (op5 <= 5'd3) ? FORM_LSL_IMM :
                           (op5 <= 5'd7) ? FORM_LSR_IMM : FORM_ASR_IMM;
                res.dest_reg = {1'b0, hw[2:0]};
                res.base_reg = {1'b0, hw[5:3]};
                res.immediate = {7'd0, hw[10:6]};
            end
            else if (op5 <= 5'd15)
            begin
                res.dest_reg = {1'b0, hw[2:0]};
                res.base_reg = {1'b0, hw[5:3]};
                if (!op5[1])
                begin
                    res.form = op5[0] ? FORM_SUB_REG : FORM_ADD_REG;
                    res.index_reg = {1'b0, hw[8:6]};
                end
                else if (hw[8:6] == 3'd0)
                    res.form = FORM_MOV_LOW;
                else
                begin
                    res.form = op5[0] ? FORM_SUB_IMM3 : FORM_ADD_IMM3;
                    res.immediate = {9'd0, hw[8:6]};
                end
            end
            else
            begin
                res.immediate = {4'd0, hw[7:0]};
                case (op5[3:2])
                    2'd0: res.form = FORM_MOV_IMM8;
                    2'd1: res.form = FORM_CMP_IMM8;
                    2'd2: res.form = FORM_ADD_IMM8;
                    default: res.form = FORM_SUB_IMM8;
                endcase
                // Compare has no destination; its register is the first operand.
                if (op5[3:2] == 2'd1)
                    res.base_reg = {1'b0, hw[10:8]};
                else
                    res.dest_reg = {1'b0, hw[10:8]};
            end
        end
        else if (hw[15:10] == 6'b010001)
        begin
            op4 = hw[9:6];
            rdn = {hw[7], hw[2:0]};
            if (op4 <= 4'd3)
            begin
                res.form = FORM_ADD_HIGH;
                res.dest_reg = rdn;
                res.base_reg = rdn;
                res.index_reg = hw[6:3];
            end
            else if (op4 >= 4'd8 && op4 <= 4'd11)
            begin
                res.form = FORM_MOV_HIGH;
                res.dest_reg = rdn;
                res.base_reg = hw[6:3];
            end
            else if (op4 >= 4'd5 && op4 <= 4'd7)
            begin
                res.form = FORM_CMP_HIGH;
                res.base_reg = rdn;
                res.index_reg = hw[6:3];
            end
            else if (op4 >= 4'd12)
            begin
                res.form = op4[1] ? FORM_BLX : FORM_BX;
                res.index_reg = hw[6:3];
            end
        end
        else if (hw[15:12] == 4'hB)
        begin
            if (hw[11:8] == 4'h0)
            begin
                res.form = hw[7] ? FORM_SUB_SP : FORM_ADD_SP;
                res.dest_reg = REG_SP;
                res.base_reg = REG_SP;
                res.immediate = {3'd0, hw[6:0], 2'b00};
            end
        end
        else if (hw[15:12] == 4'h6)
        begin
            res.form = hw[11] ? FORM_LDR_IMM5 : FORM_STR_IMM5;
            res.dest_reg = {1'b0, hw[2:0]};
            res.base_reg = {1'b0, hw[5:3]};
            res.immediate = {5'd0, hw[10:6], 2'b00};
        end
        else if (hw[15:12] == 4'h9)
        begin
            res.form = hw[11] ? FORM_LDR_SP : FORM_STR_SP;
            res.dest_reg = {1'b0, hw[10:8]};
            res.base_reg = REG_SP;
            res.immediate = {2'd0, hw[7:0], 2'b00};
        end
        return 1'b1;
    endfunction

    // Called and returning at a falling edge; valid stays high straight into the next
    // transaction when no gap is drawn.
    task automatic send_halfword(input logic [15:0] hw, input logic typed,
                                 input decoded_t typed_res);
        decoded_t predicted;
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        halfword <= hw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (predict_decode(hw, predicted))
            pending_decodes.push_back(typed ? typed_res : predicted);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_decodes.size() != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        decoded_t got_res;
        decoded_t want_res;
        if (rst_n && out_valid && !out_stall)
        begin
            got_res = '{form, wide, dest_reg, base_reg, index_reg, immediate, shift_amount,
                        reg_mask, writeback, raw_word};
            stall_left = rx_calm ? 0 : $urandom_range(0, 9);
            if (pending_decodes.size() == 0)
            begin
                decode_errors++;
                if (decode_errors <= REPORT_LIMIT)
                    $display("unexpected decode transaction, raw %h form %0d",
                             got_res.raw_word, got_res.form);
            end
            else
            begin
                want_res = pending_decodes.pop_front();
                if (got_res !== want_res)
                begin
                    decode_errors++;
                    if (decode_errors <= REPORT_LIMIT)
                    begin
                        $display("decode mismatch, raw %h", want_res.raw_word);
                        $display({"  expected form %0d wide %0d rd %0d rn %0d rm %0d",
                                  " imm %h sh %0d list %h wb %0d raw %h"},
                                 want_res.form, want_res.wide, want_res.dest_reg,
                                 want_res.base_reg, want_res.index_reg, want_res.immediate,
                                 want_res.shift_amount, want_res.reg_mask, want_res.writeback,
                                 want_res.raw_word);
                        $display({"  actual   form %0d wide %0d rd %0d rn %0d rm %0d",
                                  " imm %h sh %0d list %h wb %0d raw %h"},
                                 got_res.form, got_res.wide, got_res.dest_reg,
                                 got_res.base_reg, got_res.index_reg, got_res.immediate,
                                 got_res.shift_amount, got_res.reg_mask, got_res.writeback,
                                 got_res.raw_word);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int i;
        int kind;
        logic [15:0] first_half;
        logic [15:0] second_half;
        logic [15:0] hw;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < DIRECTED_COUNT; i++)
            send_halfword(DIRECTED_ROWS[i].hw, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
        hold_until_drained();

        while (sent_count < ITEM_TARGET)
        begin
            // Switch now and then between idling and back-to-back stretches.
            if ($urandom_range(0, 119) == 0)
            begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 299) == 0)
                hold_until_drained();
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                hw = 16'($urandom);
                case ($urandom_range(0, 3))
                    0: hw[15:10] = 6'b010001;
                    1: hw[15:8] = 8'hB0;
                    default: ;
                endcase
                // Keep this a single-halfword instruction.
                if (hw[15:12] == PREFIX_F || hw[15:11] == PREFIX_E8)
                    hw[15] = 1'b0;
                send_halfword(hw, 1'b0, NO_RES);
            end
            else if (kind < 85)
            begin
                first_half = 16'($urandom);
                case ($urandom_range(0, 4))
                    0: first_half[15:9] = {PREFIX_E8, 2'b00};
                    1: first_half[15:8] = 8'hF8;
                    2: first_half[15:11] = 5'b11111;
                    3: first_half[15:11] = 5'b11110;
                    default: first_half[15:11] = PREFIX_E8;
                endcase
                case ($urandom_range(0, 7))
                    0: first_half[3:0] = REG_SP;
                    1: first_half[3:0] = REG_PC;
                    default: ;
                endcase
                second_half = 16'($urandom);
                if ($urandom_range(0, 2) == 0)
                    second_half[11:6] = 6'd0;
                send_halfword(first_half, 1'b0, NO_RES);
                send_halfword(second_half, 1'b0, NO_RES);
            end
            else
            begin
                // Raw noise: may open a 32-bit instruction that the next item completes.
                hw = 16'($urandom);
                send_halfword(hw, 1'b0, NO_RES);
            end
        end

        in_valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (decode_errors == 0 && pending_decodes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
